>>> hw/rtl/ofiw_pkg.sv
package ofiw_pkg;

  localparam int unsigned MaxLevels   = 16;
  localparam int unsigned LevelBits   = 4;
  localparam int unsigned WinEntries  = 256;
  localparam int unsigned WinIdxBits  = 8;
  localparam int unsigned CountBits   = 9;
  localparam int unsigned PriceBits   = 32;
  localparam int unsigned QtyBits     = 32;
  localparam int unsigned WeightBits  = 17;
  localparam int unsigned EventBits   = 34;
  localparam int unsigned TermBits    = EventBits + WeightBits;
  localparam int unsigned DepthBits   = 38;
  localparam int unsigned WDepthBits  = 48;
  localparam int unsigned DivBits     = 64 + CountBits;
  localparam int unsigned DivCntBits  = 7;

  // Register byte addresses (64-bit data port, 8-byte stride).
  localparam logic [3:0] AddrLevelsUsed = 4'h0;
  localparam logic [3:0] AddrWindowLen  = 4'h8;

  localparam logic [4:0]  LevelsUsedRst = 5'd5;
  localparam logic [47:0] WindowLenRst  = 48'd1000000000;

  // Level weight, round(2^16 / (k + 1)).
  function automatic logic [WeightBits-1:0] level_weight(input logic [LevelBits-1:0] k);
    logic [WeightBits-1:0] w;
    case (k)
      4'd0:    w = 17'd65536;
      4'd1:    w = 17'd32768;
      4'd2:    w = 17'd21845;
      4'd3:    w = 17'd16384;
      4'd4:    w = 17'd13107;
      4'd5:    w = 17'd10923;
      4'd6:    w = 17'd9362;
      4'd7:    w = 17'd8192;
      4'd8:    w = 17'd7282;
      4'd9:    w = 17'd6554;
      4'd10:   w = 17'd5958;
      4'd11:   w = 17'd5461;
      4'd12:   w = 17'd5041;
      4'd13:   w = 17'd4681;
      4'd14:   w = 17'd4369;
      default: w = 17'd4096;
    endcase
    return w;
  endfunction

  // Order flow event of one side; a bid improves upward, an ask downward.
  function automatic logic signed [EventBits-1:0] side_event(
    input logic [PriceBits-1:0] np,
    input logic [QtyBits-1:0]   nq,
    input logic [PriceBits-1:0] pp,
    input logic [QtyBits-1:0]   pq,
    input logic                 is_bid
  );
    logic signed [EventBits-1:0] pos_q;
    logic signed [EventBits-1:0] neg_q;
    logic signed [EventBits-1:0] r;
    logic better;
    logic worse;
    pos_q  = $signed({2'b00, nq});
    neg_q  = -$signed({2'b00, pq});
    better = is_bid ? (np > pp) : (np < pp);
    worse  = is_bid ? (np < pp) : (np > pp);
    if (pp == '0 && np == '0) begin
      r = '0;
    end else if (pp == '0) begin
      r = pos_q;
    end else if (np == '0) begin
      r = neg_q;
    end else if (better) begin
      r = pos_q;
    end else if (worse) begin
      r = neg_q;
    end else begin
      r = pos_q + neg_q;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/order_flow_imbalance_window_core.sv
// Level item: accepted in S_IDLE, then S_LEVEL alone when the level is skipped, or
// S_LEVEL (event), S_MUL (weight multiply) and S_ACC (saturating add) when it counts.
// Snapshot end: S_EVRD and S_EVCHK for each evicted window entry, then push, product,
// the bit-serial divider and saturation (divider and saturation skipped for zero depth).
// Reset (rst_ni low, asynchronous) clears all control state and the window sums;
// the level stores and the ring memory are not cleared and need no clearing pass.
module order_flow_imbalance_window_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Level requests in.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: bid_price[31:0], bid_qty[63:32], ask_price[95:64],
  // ask_qty[127:96], snap_time[191:128].
  input  logic [191:0] s_axis_tdata,
  // tuser: carries_level.
  input  logic         s_axis_tuser,
  // tlast: snapshot_end.
  input  logic         s_axis_tlast,
  // Results out.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: imbalance_value[63:0], window_entries[72:64], zero fill.
  output logic [79:0]  m_axis_tdata,
  // tuser from bit 0: warming_up, window_overflow.
  output logic [1:0]   m_axis_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import ofiw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_MUL, S_ACC, S_END, S_EVRD, S_EVCHK,
    S_PUSH, S_NMUL, S_DIV, S_SAT, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [4:0]  levels_used_q;
  logic [47:0] window_len_q;

  // Latched request.
  logic [PriceBits-1:0] bp_q, ap_q;
  logic [QtyBits-1:0]   bq_q, aq_q;
  logic                 end_q;
  logic [63:0]          ts_q;

  // Previous snapshot levels.
  logic [PriceBits-1:0] prev_bp_q [MaxLevels];
  logic [QtyBits-1:0]   prev_bq_q [MaxLevels];
  logic [PriceBits-1:0] prev_ap_q [MaxLevels];
  logic [QtyBits-1:0]   prev_aq_q [MaxLevels];

  logic [4:0]            pos_q, plc_q;
  logic                  primed_q;
  logic signed [63:0]    sca_q;
  logic [DepthBits-1:0]  sda_q;
  logic [EventBits-1:0]  emag_q;
  logic                  eneg_q;
  logic [TermBits-1:0]   term_q;

  // Window ring and its running sums.
  logic [63:0]           ring_time_mem   [WinEntries];
  logic [63:0]           ring_contrib_mem[WinEntries];
  logic [DepthBits-1:0]  ring_depth_mem  [WinEntries];
  logic [63:0]           rd_time_q, rd_contrib_q;
  logic [DepthBits-1:0]  rd_depth_q;
  logic [WinIdxBits-1:0] head_q;
  logic [CountBits-1:0]  cnt_q;
  logic [63:0]           wcs_q;
  logic [WDepthBits-1:0] wds_q;
  logic [63:0]           cutoff_q;
  logic                  ovf_q;

  // Divider.
  logic [DivBits-1:0]    dvd_q;
  logic [WDepthBits-1:0] rem_q;
  logic [DivCntBits-1:0] dcnt_q;
  logic                  neg_q;
  logic [63:0]           res_val_q;
  logic                  res_warm_q;

  // Output register.
  logic        out_valid_q;
  logic [63:0] out_val_q;
  logic        out_warm_q, out_ovf_q;
  logic [CountBits-1:0] out_cnt_q;

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_cnt_q, out_val_q};
  assign m_axis_tuser  = {out_ovf_q, out_warm_q};

  always_comb begin
    if (paddr[3]) begin
      prdata = {16'b0, window_len_q};
    end else begin
      prdata = {59'b0, levels_used_q};
    end
  end

  logic in_acc, cfg_wr;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Level event path, evaluated in S_LEVEL from the latched request.
  logic [LevelBits-1:0]        k;
  logic                        have;
  logic [4:0]                  lu;
  logic                        active;
  logic signed [EventBits-1:0] eb, ea;
  logic signed [EventBits:0]   e_full;
  logic [EventBits:0]          e_mag;
  logic [DepthBits+1:0]        dsum;

  assign k      = pos_q[LevelBits-1:0];
  assign have   = pos_q < plc_q;
  assign lu     = (levels_used_q > 5'(MaxLevels)) ? 5'(MaxLevels) : levels_used_q;
  assign active = primed_q && (pos_q < lu);
  assign eb = side_event(bp_q, bq_q, have ? prev_bp_q[k] : '0,
                         have ? prev_bq_q[k] : '0, 1'b1);
  assign ea = side_event(ap_q, aq_q, have ? prev_ap_q[k] : '0,
                         have ? prev_aq_q[k] : '0, 1'b0);
  assign e_full = {eb[EventBits-1], eb} - {ea[EventBits-1], ea};
  assign e_mag  = e_full[EventBits] ? 35'(-e_full) : 35'(e_full);
  assign dsum   = {2'b00, sda_q} + {8'b0, bq_q} + {8'b0, aq_q};

  // Saturating add of the weighted term.
  logic signed [64:0] term_s, acc_sum;
  assign term_s  = eneg_q ? -$signed({14'b0, term_q}) : $signed({14'b0, term_q});
  assign acc_sum = {sca_q[63], sca_q} + term_s;

  // Divider step and normalization.
  logic [WDepthBits:0]   trial;
  logic                  q_bit;
  logic [63:0]           wmag;
  logic [63:0]           limit;
  logic [DivBits-1:0]    tot;
  assign trial = {rem_q, dvd_q[DivBits-1]};
  assign q_bit = trial >= {1'b0, wds_q};
  assign wmag  = wcs_q[63] ? -wcs_q : wcs_q;
  assign limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign tot   = (dvd_q > {9'b0, limit}) ? {9'b0, limit} : dvd_q;

  logic [WinIdxBits-1:0] slot;
  assign slot = head_q + cnt_q[WinIdxBits-1:0];

  // The ring memory: one write port at the push, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (state_q == S_PUSH) begin
      ring_time_mem[slot]    <= ts_q;
      ring_contrib_mem[slot] <= sca_q;
      ring_depth_mem[slot]   <= sda_q;
    end
    if (state_q == S_EVRD) begin
      rd_time_q    <= ring_time_mem[head_q];
      rd_contrib_q <= ring_contrib_mem[head_q];
      rd_depth_q   <= ring_depth_mem[head_q];
    end
  end

  // Level stores hold payload only and take no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LEVEL) begin
      prev_bp_q[k] <= bp_q;
      prev_bq_q[k] <= bq_q;
      prev_ap_q[k] <= ap_q;
      prev_aq_q[k] <= aq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      levels_used_q <= LevelsUsedRst;
      window_len_q  <= WindowLenRst;
      pos_q         <= '0;
      plc_q         <= '0;
      primed_q      <= 1'b0;
      sca_q         <= '0;
      sda_q         <= '0;
      head_q        <= '0;
      cnt_q         <= '0;
      wcs_q         <= '0;
      wds_q         <= '0;
      ovf_q         <= 1'b0;
      dcnt_q        <= '0;
      out_valid_q   <= 1'b0;
      bp_q <= '0; bq_q <= '0; ap_q <= '0; aq_q <= '0;
      end_q <= 1'b0; ts_q <= '0;
      emag_q <= '0; eneg_q <= 1'b0; term_q <= '0;
      cutoff_q <= '0; dvd_q <= '0; rem_q <= '0; neg_q <= 1'b0;
      res_val_q <= '0; res_warm_q <= 1'b0;
      out_val_q <= '0; out_warm_q <= 1'b0; out_ovf_q <= 1'b0; out_cnt_q <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[3] == AddrWindowLen[3]) begin
          window_len_q <= pwdata[47:0];
        end else begin
          levels_used_q <= pwdata[4:0];
        end
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            bp_q  <= s_axis_tdata[31:0];
            bq_q  <= s_axis_tdata[63:32];
            ap_q  <= s_axis_tdata[95:64];
            aq_q  <= s_axis_tdata[127:96];
            ts_q  <= s_axis_tdata[191:128];
            end_q <= s_axis_tlast;
            if (s_axis_tuser && pos_q < 5'(MaxLevels)) begin
              state_q <= S_LEVEL;
            end else if (s_axis_tlast) begin
              state_q <= S_END;
            end
          end
        end
        S_LEVEL: begin
          pos_q <= pos_q + 5'd1;
          if (active) begin
            emag_q <= e_mag[EventBits-1:0];
            eneg_q <= e_full[EventBits];
            sda_q  <= (dsum > {2'b00, {DepthBits{1'b1}}}) ? {DepthBits{1'b1}}
                                                         : dsum[DepthBits-1:0];
            state_q <= S_MUL;
          end else begin
            state_q <= end_q ? S_END : S_IDLE;
          end
        end
        S_MUL: begin
          term_q  <= TermBits'(emag_q) * TermBits'(level_weight(k - 4'd1));
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (acc_sum[64] != acc_sum[63]) begin
            sca_q <= acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
          end else begin
            sca_q <= acc_sum[63:0];
          end
          state_q <= end_q ? S_END : S_IDLE;
        end
        S_END: begin
          plc_q <= pos_q;
          pos_q <= '0;
          ovf_q <= 1'b0;
          if (!primed_q) begin
            primed_q   <= 1'b1;
            sca_q      <= '0;
            sda_q      <= '0;
            res_val_q  <= '0;
            res_warm_q <= 1'b1;
            state_q    <= S_OUT;
          end else begin
            cutoff_q <= (ts_q > {16'b0, window_len_q}) ? ts_q - {16'b0, window_len_q} : '0;
            state_q  <= S_EVRD;
          end
        end
        S_EVRD: begin
          state_q <= S_EVCHK;
        end
        S_EVCHK: begin
          if ((cnt_q != '0 && rd_time_q < cutoff_q) || cnt_q == CountBits'(WinEntries)) begin
            wcs_q  <= wcs_q - rd_contrib_q;
            wds_q  <= wds_q - {10'b0, rd_depth_q};
            head_q <= head_q + 1'b1;
            cnt_q  <= cnt_q - 1'b1;
            if (cnt_q != '0 && rd_time_q < cutoff_q) begin
              state_q <= S_EVRD;
            end else begin
              ovf_q   <= 1'b1;
              state_q <= S_PUSH;
            end
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          cnt_q   <= cnt_q + 1'b1;
          wcs_q   <= wcs_q + sca_q;
          wds_q   <= wds_q + {10'b0, sda_q};
          sca_q   <= '0;
          sda_q   <= '0;
          state_q <= S_NMUL;
        end
        S_NMUL: begin
          neg_q      <= wcs_q[63];
          dvd_q      <= DivBits'(wmag) * DivBits'(cnt_q);
          rem_q      <= '0;
          dcnt_q     <= '0;
          res_warm_q <= 1'b0;
          if (wds_q == '0) begin
            res_val_q <= '0;
            state_q   <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          rem_q  <= q_bit ? 48'(trial - {1'b0, wds_q}) : trial[WDepthBits-1:0];
          dvd_q  <= {dvd_q[DivBits-2:0], q_bit};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DivCntBits'(DivBits - 1)) begin
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          res_val_q <= neg_q ? -tot[63:0] : tot[63:0];
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_warm_q  <= res_warm_q;
            out_ovf_q   <= ovf_q;
            out_cnt_q   <= cnt_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountBits'(WinEntries))
    else $error("window count above ring depth");
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NMUL) |-> (cnt_q != '0))
    else $error("window empty after push");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 5'(MaxLevels))
    else $error("level position beyond store depth");
  a_warm_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_warm_q) |-> (out_cnt_q == '0 && out_val_q == '0))
    else $error("priming result not empty");

endmodule

>>> tb/order_flow_imbalance_window_core_tb.sv
`timescale 1ns / 100ps

module order_flow_imbalance_window_core_tb;
  import ofiw_pkg::*;

  localparam longint unsigned CycleLimit = 64'd3000000;
  localparam logic [63:0] Int64Max = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] Int64Min = 64'h8000_0000_0000_0000;
  localparam logic [37:0] DepthSatMax = {38{1'b1}};
  localparam int unsigned ExpDepth = 1024;

  typedef struct packed {
    logic [63:0] imbalance;
    logic        warming;
    logic        overflow;
    logic [8:0]  entries;
  } ofi_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  order_flow_imbalance_window_core DUT (.*);

  // Mirror of the block state used to predict each snapshot result.
  logic [31:0]  bid_px_hist [MaxLevels];
  logic [31:0]  bid_qty_hist[MaxLevels];
  logic [31:0]  ask_px_hist [MaxLevels];
  logic [31:0]  ask_qty_hist[MaxLevels];
  int unsigned  hist_levels;
  int unsigned  level_idx;
  bit           is_primed;
  logic [63:0]  snap_contrib;
  logic [37:0]  snap_depth;
  logic [63:0]  win_time  [WinEntries];
  logic [63:0]  win_contrib[WinEntries];
  logic [37:0]  win_depth [WinEntries];
  int unsigned  win_head;
  int unsigned  win_count;
  logic [63:0]  win_contrib_sum;
  logic [47:0]  win_depth_sum;
  logic [4:0]   cfg_levels;
  logic [47:0]  cfg_window_ns;

  ofi_result_t  expected_results[ExpDepth];
  int unsigned  exp_wr;
  int unsigned  exp_rd;
  int unsigned  mismatch_count;
  bit           hold_results;
  int unsigned  long_hold_cycles;
  longint unsigned cycle_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("order_flow_imbalance_window_core test failed");
      $finish;
    end
  end

  // Saturating signed 64-bit add.
  function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return Int64Max;
    if (a[63] && b[63] && !s[63]) return Int64Min;
    return s;
  endfunction

  // Order flow event of one book side, 34-bit signed, held in 64 bits.
  function automatic logic [63:0] book_side_flow(logic [31:0] np, logic [31:0] nq,
                                                 logic [31:0] pp, logic [31:0] pq,
                                                 bit bid_side);
    logic [63:0] gain;
    logic [63:0] loss;
    bit improved;
    bit worsened;
    gain = {32'd0, nq};
    loss = -{32'd0, pq};
    improved = bid_side ? (np > pp) : (np < pp);
    worsened = bid_side ? (np < pp) : (np > pp);
    if (pp == 0 && np == 0) return 64'd0;
    if (pp == 0) return gain;
    if (np == 0) return loss;
    if (improved) return gain;
    if (worsened) return loss;
    return gain + loss;
  endfunction

  function automatic logic [63:0] depth_weight(int unsigned k);
    return ((64'd1 << 16) + (k + 1) / 2) / (k + 1);
  endfunction

  // Window contribution times count over window depth, truncated, saturated.
  function automatic logic [63:0] window_imbalance();
    logic [63:0] mag;
    logic [63:0] lim;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] tot;
    logic [63:0] extra;
    logic [63:0] dd;
    bit neg;
    dd = {16'd0, win_depth_sum};
    if (dd == 0 || win_count == 0) return 64'd0;
    neg = win_contrib_sum[63];
    mag = neg ? -win_contrib_sum : win_contrib_sum;
    lim = neg ? Int64Min : Int64Max;
    q = mag / dd;
    r = mag % dd;
    if (q > lim / win_count) begin
      tot = lim;
    end else begin
      tot = q * win_count;
      extra = (r * win_count) / dd;
      tot = (extra > lim - tot) ? lim : tot + extra;
    end
    return neg ? -tot : tot;
  endfunction

  function automatic void evict_oldest();
    win_contrib_sum = win_contrib_sum - win_contrib[win_head];
    win_depth_sum = win_depth_sum - win_depth[win_head][37:0];
    win_head = (win_head + 1) % WinEntries;
    win_count--;
  endfunction

  function automatic void absorb_level(logic [31:0] bp, logic [31:0] bq,
                                       logic [31:0] ap, logic [31:0] aq);
    int unsigned k;
    int unsigned lim_levels;
    bit have;
    logic [63:0] eb;
    logic [63:0] ea;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] w;
    logic [63:0] term;
    logic [38:0] dsum;
    k = level_idx;
    lim_levels = (cfg_levels > MaxLevels) ? MaxLevels : cfg_levels;
    if (k >= MaxLevels) return;
    if (is_primed && k < lim_levels) begin
      have = k < hist_levels;
      eb = book_side_flow(bp, bq, have ? bid_px_hist[k] : 32'd0,
                          have ? bid_qty_hist[k] : 32'd0, 1'b1);
      ea = book_side_flow(ap, aq, have ? ask_px_hist[k] : 32'd0,
                          have ? ask_qty_hist[k] : 32'd0, 1'b0);
      e = eb - ea;
      m = e[63] ? -e : e;
      w = depth_weight(k);
      if (m > Int64Max / w) term = e[63] ? Int64Min : Int64Max;
      else term = e[63] ? -(m * w) : m * w;
      snap_contrib = add_sat64(snap_contrib, term);
      dsum = {1'b0, snap_depth} + bq + aq;
      snap_depth = (dsum > DepthSatMax) ? DepthSatMax : dsum[37:0];
    end
    bid_px_hist[k] = bp;
    bid_qty_hist[k] = bq;
    ask_px_hist[k] = ap;
    ask_qty_hist[k] = aq;
    level_idx = k + 1;
  endfunction

  function automatic void close_snapshot(logic [63:0] ts);
    ofi_result_t res;
    logic [63:0] cutoff;
    int unsigned slot;
    res = '0;
    hist_levels = level_idx;
    level_idx = 0;
    if (!is_primed) begin
      is_primed = 1'b1;
      snap_contrib = '0;
      snap_depth = '0;
      res.warming = 1'b1;
      res.entries = win_count[8:0];
      expected_results[exp_wr % ExpDepth] = res;
      exp_wr++;
      return;
    end
    cutoff = (ts > {16'd0, cfg_window_ns}) ? ts - {16'd0, cfg_window_ns} : 64'd0;
    while (win_count > 0 && win_time[win_head] < cutoff) evict_oldest();
    if (win_count >= WinEntries) begin
      evict_oldest();
      res.overflow = 1'b1;
    end
    slot = (win_head + win_count) % WinEntries;
    win_time[slot] = ts;
    win_contrib[slot] = snap_contrib;
    win_depth[slot] = snap_depth;
    win_count++;
    win_contrib_sum = win_contrib_sum + snap_contrib;
    win_depth_sum = win_depth_sum + snap_depth;
    snap_contrib = '0;
    snap_depth = '0;
    res.imbalance = window_imbalance();
    res.entries = win_count[8:0];
    expected_results[exp_wr % ExpDepth] = res;
    exp_wr++;
  endfunction

  // Sends one level request, updating the prediction when it is accepted.
  // tvalid stays high into a request that follows without a gap.
  task automatic send_level(logic [31:0] bp, logic [31:0] bq, logic [31:0] ap,
                            logic [31:0] aq, bit has_level, bit ends_snap,
                            logic [63:0] ts, bit allow_gap = 1'b1);
    int unsigned gap;
    gap = allow_gap ? $urandom_range(14, 0) : 0;
    if ($urandom_range(3, 0) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ts, aq, ap, bq, bp};
    s_axis_tuser <= has_level;
    s_axis_tlast <= ends_snap;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (has_level) absorb_level(bp, bq, ap, aq);
    if (ends_snap) close_snapshot(ts);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == AddrLevelsUsed) cfg_levels = data[4:0];
    else cfg_window_ns = data[47:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every predicted result has come back, then lets the block settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  // Random snapshot: mostly plausible books around fixed base prices, some noise.
  task automatic send_snapshot(int unsigned nlev, ref logic [63:0] ts,
                               input logic [63:0] step);
    logic [31:0] bp;
    logic [31:0] ap;
    logic [31:0] bq;
    logic [31:0] aq;
    int unsigned mode;
    ts = ts + step;
    for (int unsigned i = 0; i < nlev; i++) begin
      mode = $urandom_range(9, 0);
      bp = 32'd1000 - 5 * i + $urandom_range(2, 0);
      ap = 32'd1010 + 5 * i - $urandom_range(2, 0);
      bq = $urandom_range(500, 1);
      aq = $urandom_range(500, 1);
      if (mode == 0) begin
        bp = 0;
        bq = 0;
      end else if (mode == 1) begin
        ap = 0;
        aq = 0;
      end else if (mode == 2) begin
        bp = $urandom;
        bq = $urandom;
        ap = $urandom;
        aq = $urandom;
      end
      if ($urandom_range(15, 0) == 0) send_level(0, 0, 0, 0, 1'b0, 1'b0, ts);
      send_level(bp, bq, ap, aq, 1'b1, i == nlev - 1, ts);
    end
    if (nlev == 0) send_level($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1, ts);
  endtask

  // Extreme fields, every side case, empty snapshot and ignored items.
  task automatic test_directed();
    logic [63:0] ts;
    ts = 64'd100;
    send_level(32'd100, 32'd10, 32'd110, 32'd20, 1'b1, 1'b0, ts);
    send_level(32'd99, 32'd5, 32'd0, 32'd0, 1'b1, 1'b1, ts);
    send_level(32'd101, 32'd7, 32'd109, 32'd8, 1'b1, 1'b0, ts + 10);
    send_level(32'd98, 32'd6, 32'd111, 32'd9, 1'b1, 1'b0, ts + 10);
    send_level(32'd0, 32'd0, 32'd112, 32'd3, 1'b1, 1'b1, ts + 10);
    send_level(32'd101, 32'd9, 32'd109, 32'd1, 1'b1, 1'b1, ts + 20);
    send_level('1, '1, '1, '1, 1'b0, 1'b0, '1);
    send_level('1, '1, 32'd1, '1, 1'b1, 1'b0, ts + 30);
    send_level(32'd1, '1, '1, '1, 1'b1, 1'b1, ts + 30);
    send_level('1, '1, '1, '1, 1'b1, 1'b1, ts + 40);
    send_level(0, 0, 0, 0, 1'b0, 1'b1, ts + 50);
    send_level(0, 0, 0, 0, 1'b0, 1'b1, 64'd0);
    send_level(32'd5, 32'd5, 32'd6, 32'd5, 1'b1, 1'b1, 64'hffff_ffff_ffff_fff0);
    for (int unsigned i = 0; i < 18; i++)
      send_level('1 - i, '1, i + 1, '1, 1'b1, i == 17, 64'hffff_ffff_ffff_fff8);
    drain_results();
  endtask

  // Walk levels_used and window length through their ranges.
  task automatic test_config_sweep();
    logic [63:0] ts;
    logic [4:0] lv_set[5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7};
    logic [47:0] win_set[5] = '{48'd0, 48'd50, '1, 48'd400, 48'd1000000000};
    ts = 64'd1000000;
    foreach (lv_set[j]) begin
      write_reg(AddrLevelsUsed, {$urandom, $urandom} & ~64'h1f | lv_set[j]);
      write_reg(AddrWindowLen, {16'hffff, win_set[j]} ^ {16'h0, 48'h0});
      for (int unsigned n = 0; n < 8; n++)
        send_snapshot($urandom_range(17, 0), ts, $urandom_range(120, 1));
      drain_results();
    end
  endtask

  // Long window with many tiny snapshots so the ring fills and overflows.
  task automatic test_ring_overflow();
    logic [63:0] ts;
    ts = 64'd50000000;
    write_reg(AddrLevelsUsed, 64'd2);
    write_reg(AddrWindowLen, {16'd0, 48'hffff_ffff_ffff});
    for (int unsigned n = 0; n < 280; n++) send_snapshot(1, ts, 1);
    drain_results();
    // A large time jump evicts all entries at once.
    write_reg(AddrWindowLen, 64'd10);
    send_snapshot(2, ts, 64'd5000);
    drain_results();
  endtask

  // Random snapshots with a long receiver stall in the middle.
  task automatic test_random();
    logic [63:0] ts;
    ts = 64'd90000000;
    write_reg(AddrLevelsUsed, 64'd5);
    write_reg(AddrWindowLen, 64'd2000);
    for (int unsigned n = 0; n < 60; n++) begin
      if (n == 40) long_hold_cycles = 3000;
      send_snapshot($urandom_range(6, 0), ts, $urandom_range(300, 1));
    end
    drain_results();
  endtask

  // Long receiver stall, counted here; the checker keeps tready low meanwhile.
  initial begin
    hold_results = 1'b0;
    wait (long_hold_cycles != 0);
    hold_results = 1'b1;
    repeat (long_hold_cycles) @(posedge clk_i);
    hold_results = 1'b0;
  end

  // Result checker with random back-pressure and an optional long stall.
  initial begin
    int unsigned stall;
    ofi_result_t want;
    ofi_result_t got;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        while (hold_results) @(posedge clk_i);
      end
      stall = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(14, 0);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.imbalance = m_axis_tdata[63:0];
      got.entries = m_axis_tdata[72:64];
      got.warming = m_axis_tuser[0];
      got.overflow = m_axis_tuser[1];
      if (exp_wr == exp_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results[exp_rd % ExpDepth];
        exp_rd++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    s_axis_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    long_hold_cycles = 0;
    exp_wr = 0;
    exp_rd = 0;
    hist_levels = 0;
    level_idx = 0;
    is_primed = 1'b0;
    snap_contrib = '0;
    snap_depth = '0;
    win_head = 0;
    win_count = 0;
    win_contrib_sum = '0;
    win_depth_sum = '0;
    cfg_levels = LevelsUsedRst;
    cfg_window_ns = WindowLenRst;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_ring_overflow();
    test_random();
    drain_results();
    if (mismatch_count == 0 && exp_wr == exp_rd) begin
      $display("order_flow_imbalance_window_core test passed");
    end else begin
      $display("order_flow_imbalance_window_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ofiw_pkg.sv
hw/rtl/order_flow_imbalance_window_core.sv
tb/order_flow_imbalance_window_core_tb.sv
